// File: src/isodtp_pkg.sv
// ============================================================================
// isodtp_pkg
// Shared constants for the ISO date-time string parser: character codes,
// field widths, range limits and time zone kinds.
// ============================================================================
`default_nettype none

package isodtp_pkg;

    localparam int YEAR_W   = 21;
    localparam int MONTH_W  = 5;
    localparam int DAY_W    = 6;
    localparam int HOUR_W   = 6;
    localparam int MINUTE_W = 7;
    localparam int SECOND_W = 7;
    localparam int MILLI_W  = 11;
    localparam int ZKIND_W  = 2;
    localparam int ACCUM_W  = 20;
    localparam int COUNT_W  = 3;

    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [6:0] HOUR_MAX   = 7'd24;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] MONTH_MIN  = 7'd1;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MIN    = 7'd1;
    localparam logic [6:0] DAY_MAX    = 7'd31;

    localparam logic [COUNT_W-1:0] DIGITS_YEAR4 = 3'd4;
    localparam logic [COUNT_W-1:0] DIGITS_YEAR6 = 3'd6;
    localparam logic [COUNT_W-1:0] DIGITS_MILLI = 3'd3;
    localparam logic [COUNT_W-1:0] DIGITS_PAIR  = 3'd2;
    localparam logic [COUNT_W-1:0] DIGITS_NONE  = 3'd0;

    localparam logic [ZKIND_W-1:0] ZONE_NONE  = 2'd0;
    localparam logic [ZKIND_W-1:0] ZONE_UTC   = 2'd1;
    localparam logic [ZKIND_W-1:0] ZONE_PLUS  = 2'd2;
    localparam logic [ZKIND_W-1:0] ZONE_MINUS = 2'd3;

endpackage

`default_nettype wire

// File: src/iso_date_time_string_parser.sv
// ============================================================================
// iso_date_time_string_parser
// Parses an ECMAScript ISO date-time string one character per transfer and
// returns the decoded fields with a match flag on the final character.
// ============================================================================
//
//  channel | signals                               | direction | transfer
//  --------+---------------------------------------+-----------+----------------------
//  in      | in_valid, in_ready, char_byte, is_last| into      | in_valid & in_ready
//  out     | out_valid, out_ready, valid_res, ...  | out of    | out_valid & out_ready
//
//  One character per cycle while in_ready is high; the parser state updates on each input transfer.
//  The result is registered and shows on out_valid in the cycle after the
//  transfer of the character that carries is_last.
//  in_ready is low only while a result waits in the output register and
//  out_ready is low.
//  rst_n clears the parser to the start of the year with all fields absent.
//
`default_nettype none

module iso_date_time_string_parser
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic [7:0]                               char_byte,
    input  wire logic                                     is_last,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic                                          valid_res,
    output logic signed [isodtp_pkg::YEAR_W-1:0]          year_value,
    output logic signed [isodtp_pkg::MONTH_W-1:0]         month_value,
    output logic signed [isodtp_pkg::DAY_W-1:0]           day_value,
    output logic signed [isodtp_pkg::HOUR_W-1:0]          hour_value,
    output logic signed [isodtp_pkg::MINUTE_W-1:0]        minute_value,
    output logic signed [isodtp_pkg::SECOND_W-1:0]        second_value,
    output logic signed [isodtp_pkg::MILLI_W-1:0]         milli_value,
    output logic [isodtp_pkg::ZKIND_W-1:0]                zone_kind,
    output logic signed [isodtp_pkg::HOUR_W-1:0]          zone_hours,
    output logic signed [isodtp_pkg::MINUTE_W-1:0]        zone_minutes
);

    typedef enum logic [4:0] {
        PH_YSTART, PH_Y4, PH_Y6, PH_AYEAR, PH_MON, PH_AMON, PH_DAY, PH_ADAY,
        PH_HOUR, PH_HCOLON, PH_MIN, PH_AMIN, PH_SEC, PH_ASEC, PH_MS, PH_AMS,
        PH_ZH, PH_ZCOLON, PH_ZM, PH_AZONE
    } phase_t;

    phase_t                                       phase_reg, phase_next;
    logic [isodtp_pkg::COUNT_W-1:0]               count_reg, count_next;
    logic [isodtp_pkg::ACCUM_W-1:0]               accum_reg, accum_next;
    logic                                         neg_reg, neg_next;
    logic                                         failed_reg, failed_next;
    logic signed [isodtp_pkg::YEAR_W-1:0]         year_reg, year_next;
    logic signed [isodtp_pkg::MONTH_W-1:0]        month_reg, month_next;
    logic signed [isodtp_pkg::DAY_W-1:0]          day_reg, day_next;
    logic signed [isodtp_pkg::HOUR_W-1:0]         hour_reg, hour_next;
    logic signed [isodtp_pkg::MINUTE_W-1:0]       minute_reg, minute_next;
    logic signed [isodtp_pkg::SECOND_W-1:0]       second_reg, second_next;
    logic signed [isodtp_pkg::MILLI_W-1:0]        milli_reg, milli_next;
    logic [isodtp_pkg::ZKIND_W-1:0]               zkind_reg, zkind_next;
    logic signed [isodtp_pkg::HOUR_W-1:0]         zhours_reg, zhours_next;
    logic signed [isodtp_pkg::MINUTE_W-1:0]       zminutes_reg, zminutes_next;

    logic                                         out_valid_reg;
    logic                                         res_valid_reg;
    logic signed [isodtp_pkg::YEAR_W-1:0]         res_year_reg;
    logic signed [isodtp_pkg::MONTH_W-1:0]        res_month_reg;
    logic signed [isodtp_pkg::DAY_W-1:0]          res_day_reg;
    logic signed [isodtp_pkg::HOUR_W-1:0]         res_hour_reg;
    logic signed [isodtp_pkg::MINUTE_W-1:0]       res_minute_reg;
    logic signed [isodtp_pkg::SECOND_W-1:0]       res_second_reg;
    logic signed [isodtp_pkg::MILLI_W-1:0]        res_milli_reg;
    logic [isodtp_pkg::ZKIND_W-1:0]               res_zkind_reg;
    logic signed [isodtp_pkg::HOUR_W-1:0]         res_zhours_reg;
    logic signed [isodtp_pkg::MINUTE_W-1:0]       res_zminutes_reg;

    logic                                         in_xfer;
    logic                                         is_digit;
    logic [isodtp_pkg::COUNT_W-1:0]               need;
    logic [isodtp_pkg::COUNT_W-1:0]               count_step;
    logic [isodtp_pkg::ACCUM_W-1:0]               accum_step;
    logic [6:0]                                   pair_val;
    logic [isodtp_pkg::YEAR_W-1:0]                year_mag;
    logic                                         zone_start;
    logic                                         match_now;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign is_digit   = (char_byte >= isodtp_pkg::CHAR_ZERO) &&
                        (char_byte <= isodtp_pkg::CHAR_NINE);
    assign count_step = count_reg + 3'd1;
    assign accum_step = (accum_reg << 3) + (accum_reg << 1) +
                        {{(isodtp_pkg::ACCUM_W-4){1'b0}}, char_byte[3:0]};
    assign pair_val   = accum_step[6:0];
    assign year_mag   = {1'b0, accum_step};

    always_comb
    begin
        case (phase_reg)
            PH_Y4:   need = isodtp_pkg::DIGITS_YEAR4;
            PH_Y6:   need = isodtp_pkg::DIGITS_YEAR6;
            PH_MS:   need = isodtp_pkg::DIGITS_MILLI;
            PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_ZH, PH_ZM:
                     need = isodtp_pkg::DIGITS_PAIR;
            default: need = isodtp_pkg::DIGITS_NONE;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        accum_next    = accum_reg;
        neg_next      = neg_reg;
        failed_next   = failed_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        milli_next    = milli_reg;
        zkind_next    = zkind_reg;
        zhours_next   = zhours_reg;
        zminutes_next = zminutes_reg;
        zone_start    = 1'b0;

        if (!failed_reg)
        begin
            if (need != isodtp_pkg::DIGITS_NONE)
            begin
                if (!is_digit)
                begin
                    failed_next = 1'b1;
                end
                else if (count_step >= need)
                begin
                    accum_next = '0;
                    count_next = '0;
                    case (phase_reg)
                        PH_Y4:
                        begin
                            year_next  = year_mag;
                            phase_next = PH_AYEAR;
                        end
                        PH_Y6:
                        begin
                            year_next  = neg_reg ? -year_mag : year_mag;
                            phase_next = PH_AYEAR;
                        end
                        PH_MON:
                        begin
                            if (pair_val >= isodtp_pkg::MONTH_MIN &&
                                pair_val <= isodtp_pkg::MONTH_MAX)
                            begin
                                month_next = pair_val[isodtp_pkg::MONTH_W-1:0];
                                phase_next = PH_AMON;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_DAY:
                        begin
                            if (pair_val >= isodtp_pkg::DAY_MIN &&
                                pair_val <= isodtp_pkg::DAY_MAX)
                            begin
                                day_next   = pair_val[isodtp_pkg::DAY_W-1:0];
                                phase_next = PH_ADAY;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_HOUR:
                        begin
                            if (pair_val <= isodtp_pkg::HOUR_MAX)
                            begin
                                hour_next  = pair_val[isodtp_pkg::HOUR_W-1:0];
                                phase_next = PH_HCOLON;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_MIN:
                        begin
                            if (pair_val <= isodtp_pkg::MINUTE_MAX)
                            begin
                                minute_next = pair_val;
                                phase_next  = PH_AMIN;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_SEC:
                        begin
                            if (pair_val <= isodtp_pkg::MINUTE_MAX)
                            begin
                                second_next = pair_val;
                                phase_next  = PH_ASEC;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_MS:
                        begin
                            milli_next = {1'b0, accum_step[isodtp_pkg::MILLI_W-2:0]};
                            phase_next = PH_AMS;
                        end
                        PH_ZH:
                        begin
                            if (pair_val <= isodtp_pkg::HOUR_MAX)
                            begin
                                zhours_next = pair_val[isodtp_pkg::HOUR_W-1:0];
                                phase_next  = PH_ZCOLON;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_ZM:
                        begin
                            if (pair_val <= isodtp_pkg::MINUTE_MAX)
                            begin
                                zminutes_next = pair_val;
                                phase_next    = PH_AZONE;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            failed_next = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    accum_next = accum_step;
                    count_next = count_step;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_YSTART:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_PLUS)
                        begin
                            neg_next   = 1'b0;
                            phase_next = PH_Y6;
                        end
                        else if (char_byte == isodtp_pkg::CHAR_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_Y6;
                        end
                        else if (is_digit)
                        begin
                            accum_next = {{(isodtp_pkg::ACCUM_W-4){1'b0}}, char_byte[3:0]};
                            count_next = 3'd1;
                            phase_next = PH_Y4;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_AYEAR, PH_AMON:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_MINUS)
                        begin
                            phase_next = (phase_reg == PH_AYEAR) ? PH_MON : PH_DAY;
                        end
                        else if (char_byte == isodtp_pkg::CHAR_T)
                        begin
                            phase_next = PH_HOUR;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_ADAY:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_T)
                        begin
                            phase_next = PH_HOUR;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_HCOLON, PH_ZCOLON:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_COLON)
                        begin
                            phase_next = (phase_reg == PH_HCOLON) ? PH_MIN : PH_ZM;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_AMIN:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_COLON)
                        begin
                            phase_next = PH_SEC;
                        end
                        else
                        begin
                            zone_start = 1'b1;
                        end
                    end
                    PH_ASEC:
                    begin
                        if (char_byte == isodtp_pkg::CHAR_DOT)
                        begin
                            phase_next = PH_MS;
                        end
                        else
                        begin
                            zone_start = 1'b1;
                        end
                    end
                    PH_AMS:
                    begin
                        zone_start = 1'b1;
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase

                if (zone_start)
                begin
                    if (char_byte == isodtp_pkg::CHAR_PLUS)
                    begin
                        zkind_next = isodtp_pkg::ZONE_PLUS;
                        phase_next = PH_ZH;
                    end
                    else if (char_byte == isodtp_pkg::CHAR_MINUS)
                    begin
                        zkind_next = isodtp_pkg::ZONE_MINUS;
                        phase_next = PH_ZH;
                    end
                    else if (char_byte == isodtp_pkg::CHAR_Z)
                    begin
                        zkind_next = isodtp_pkg::ZONE_UTC;
                        phase_next = PH_AZONE;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_AYEAR, PH_AMON, PH_ADAY, PH_AMIN, PH_ASEC, PH_AMS, PH_AZONE:
                     match_now = !failed_next;
            default: match_now = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_YSTART;
            count_reg        <= '0;
            accum_reg        <= '0;
            neg_reg          <= 1'b0;
            failed_reg       <= 1'b0;
            year_reg         <= '1;
            month_reg        <= '1;
            day_reg          <= '1;
            hour_reg         <= '1;
            minute_reg       <= '1;
            second_reg       <= '1;
            milli_reg        <= '1;
            zkind_reg        <= isodtp_pkg::ZONE_NONE;
            zhours_reg       <= '1;
            zminutes_reg     <= '1;
            out_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_year_reg     <= '1;
            res_month_reg    <= '1;
            res_day_reg      <= '1;
            res_hour_reg     <= '1;
            res_minute_reg   <= '1;
            res_second_reg   <= '1;
            res_milli_reg    <= '1;
            res_zkind_reg    <= isodtp_pkg::ZONE_NONE;
            res_zhours_reg   <= '1;
            res_zminutes_reg <= '1;
        end
        else
        begin
            if (in_xfer && is_last)
            begin
                // end of string: load the result, drop back to reset state
                out_valid_reg    <= 1'b1;
                res_valid_reg    <= match_now;
                res_year_reg     <= match_now ? year_next : '1;
                res_month_reg    <= match_now ? month_next : '1;
                res_day_reg      <= match_now ? day_next : '1;
                res_hour_reg     <= match_now ? hour_next : '1;
                res_minute_reg   <= match_now ? minute_next : '1;
                res_second_reg   <= match_now ? second_next : '1;
                res_milli_reg    <= match_now ? milli_next : '1;
                res_zkind_reg    <= match_now ? zkind_next : isodtp_pkg::ZONE_NONE;
                res_zhours_reg   <= match_now ? zhours_next : '1;
                res_zminutes_reg <= match_now ? zminutes_next : '1;
                phase_reg        <= PH_YSTART;
                count_reg        <= '0;
                accum_reg        <= '0;
                neg_reg          <= 1'b0;
                failed_reg       <= 1'b0;
                year_reg         <= '1;
                month_reg        <= '1;
                day_reg          <= '1;
                hour_reg         <= '1;
                minute_reg       <= '1;
                second_reg       <= '1;
                milli_reg        <= '1;
                zkind_reg        <= isodtp_pkg::ZONE_NONE;
                zhours_reg       <= '1;
                zminutes_reg     <= '1;
            end
            else
            begin
                if (out_valid_reg && out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end

                if (in_xfer)
                begin
                    phase_reg    <= phase_next;
                    count_reg    <= count_next;
                    accum_reg    <= accum_next;
                    neg_reg      <= neg_next;
                    failed_reg   <= failed_next;
                    year_reg     <= year_next;
                    month_reg    <= month_next;
                    day_reg      <= day_next;
                    hour_reg     <= hour_next;
                    minute_reg   <= minute_next;
                    second_reg   <= second_next;
                    milli_reg    <= milli_next;
                    zkind_reg    <= zkind_next;
                    zhours_reg   <= zhours_next;
                    zminutes_reg <= zminutes_next;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = res_valid_reg;
    assign year_value   = res_year_reg;
    assign month_value  = res_month_reg;
    assign day_value    = res_day_reg;
    assign hour_value   = res_hour_reg;
    assign minute_value = res_minute_reg;
    assign second_value = res_second_reg;
    assign milli_value  = res_milli_reg;
    assign zone_kind    = res_zkind_reg;
    assign zone_hours   = res_zhours_reg;
    assign zone_minutes = res_zminutes_reg;

`ifndef ASSERT_OFF
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_last |=> phase_reg == PH_YSTART && !failed_reg && count_reg == '0)
        else $error("parser not back at year start after final character");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < isodtp_pkg::DIGITS_YEAR6)
        else $error("digit count reached a field length without closing it");

    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year_value == '1 && month_value == '1 &&
        hour_value == '1 && milli_value == '1 && zone_kind == isodtp_pkg::ZONE_NONE &&
        zone_minutes == '1)
        else $error("failed string reports parsed fields");

    a_zone_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (zone_kind == isodtp_pkg::ZONE_NONE || zone_kind == isodtp_pkg::ZONE_UTC)
        |-> zone_hours == '1 && zone_minutes == '1)
        else $error("zone offset present without a signed zone");

    a_day_needs_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && month_value == '1 |-> day_value == '1)
        else $error("day reported without a month");
`endif

endmodule

`default_nettype wire
